FILE: rtl/core/stable_priority_job_queue_top_defines.svh
// Assertion macros for the job queue RTL.
// Depends on nothing; included by stable_priority_job_queue_top, the module that carries assertions.
`ifndef STABLE_PRIORITY_JOB_QUEUE_TOP_DEFINES_SVH
`define STABLE_PRIORITY_JOB_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SPJQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SPJQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/spjq_pkg.sv
// Shared types and constants for the stable priority job queue.
// Depends on nothing; used by spjq_cell and stable_priority_job_queue_top.
package spjq_pkg;

   // Default number of job slots.
   localparam int unsigned QUEUE_DEPTH_DEF = 16;

   // Stream word widths.
   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned REQ_USER_W = 1;
   localparam int unsigned RSP_DATA_W = 56;
   localparam int unsigned RSP_USER_W = 2;
   localparam int unsigned NUM_W      = 5;

   // Operation codes carried in the request tuser.
   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;

   // Response status codes.
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_ZERO_PRI = 2'd3
   } status_type;

   // One stored job.
   typedef struct packed {
      logic [NUM_W-1:0]   num;
      logic [7:0]         act;
      logic signed [31:0] arg;
      logic [7:0]         pri;
   } entry_type;

   // Control broadcast to every cell of the chain.
   typedef struct packed {
      logic ins;   // write the new job into the slot at the tail
      logic rot;   // shift the chain one place toward slot 0
      logic keep;  // on a shift, wrap the head job around to the tail
   } cell_ctrl_type;

endpackage

FILE: rtl/core/spjq_cell.sv
// One job slot of the queue chain.
// Depends on spjq_pkg; instantiated by stable_priority_job_queue_top.
module spjq_cell #(
   parameter int unsigned QUEUE_DEPTH = spjq_pkg::QUEUE_DEPTH_DEF,
   parameter int unsigned CELL_INDEX  = 0
) (
   input  logic                                  clock,
   input  spjq_pkg::cell_ctrl_type               ctrl_i,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]      len_i,
   input  spjq_pkg::entry_type                   ins_entry_i,
   input  spjq_pkg::entry_type                   next_entry_i,
   input  spjq_pkg::entry_type                   head_entry_i,
   output spjq_pkg::entry_type                   entry_o
);
   import spjq_pkg::*;

   localparam int unsigned LEN_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [LEN_W-1:0] POS      = LEN_W'(CELL_INDEX);
   localparam logic [LEN_W-1:0] POS_NEXT = LEN_W'(CELL_INDEX + 1);

   entry_type entry_ff;
   entry_type entry_in;

   // The tail slot takes a new job or the wrapped head; slots before it take
   // their neighbor's job on a shift.
   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl_i.ins && (len_i == POS)) begin
         entry_in = ins_entry_i;
      end else if (ctrl_i.rot && (len_i > POS_NEXT)) begin
         entry_in = next_entry_i;
      end else if (ctrl_i.rot && ctrl_i.keep && (len_i == POS_NEXT)) begin
         entry_in = head_entry_i;
      end
   end

   // Slot contents are payload and need no reset.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_o = entry_ff;

endmodule

FILE: rtl/core/stable_priority_job_queue_top.sv
// Top level of the stable priority job queue: control and the cell chain.
// Depends on spjq_pkg, spjq_cell and stable_priority_job_queue_top_defines.svh.
//
//  Channel  Direction  tdata (low bit up)                         tuser
//  req      in         priority_req, argument, action_id          op
//  rsp      out        job_number, out_priority, out_argument,    status
//                      out_action_id, zero pad
//
// An insert, a refused insert or an extract from an empty queue gives its word
// in the cycle after acceptance. An extract from n stored jobs rotates the chain
// once in S_SCAN to find the job, once more in S_PURGE to squeeze it out, then
// loads the response in S_DONE once the response register is free. Reset clears
// the occupancy and the control; slot contents stay unknown. Requests are taken
// only in idle while the response register is free or being drained; a stalled
// response holds its word.
module stable_priority_job_queue_top #(
   parameter int unsigned QUEUE_DEPTH = spjq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // priority_req [7:0], argument [39:8], action_id [47:40]
   input  logic [spjq_pkg::REQ_DATA_W-1:0]   req_tdata,
   // op [0]
   input  logic [spjq_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // job_number [4:0], out_priority [12:5], out_argument [44:13],
   // out_action_id [52:45], zero [55:53]
   output logic [spjq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status [1:0]
   output logic [spjq_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import spjq_pkg::*;
   `include "stable_priority_job_queue_top_defines.svh"

   localparam int unsigned LEN_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(QUEUE_DEPTH);
   localparam logic [LEN_W-1:0] ONE_LEN   = LEN_W'(1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_PURGE,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] occ_ff, occ_in;
   logic [LEN_W-1:0] step_ff, step_in;
   logic [LEN_W-1:0] total_ff, total_in;
   logic [LEN_W-1:0] best_idx_ff, best_idx_in;
   entry_type        best_ff, best_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   entry_type        rsp_entry_ff, rsp_entry_in;

   cell_ctrl_type    cell_ctrl;
   entry_type        ins_entry;
   entry_type        cell_q [QUEUE_DEPTH];
   entry_type        head;
   logic             rsp_free;
   logic             req_accept;
   logic [31:0]      num_wide;
   logic             last_step;

   assign head       = cell_q[0];
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && rsp_free;
   assign req_accept = req_tvalid && req_tready;
   assign num_wide   = 32'(occ_ff) + 32'd1;
   assign last_step  = (step_ff == total_ff - ONE_LEN);

   // New job as it will be stored, numbered with the occupancy after insert.
   always_comb begin
      ins_entry.pri = req_tdata[7:0];
      ins_entry.arg = req_tdata[39:8];
      ins_entry.act = req_tdata[47:40];
      ins_entry.num = num_wide[NUM_W-1:0];
   end

   // Sequencer: immediate answers, the search rotation and the purge rotation.
   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      step_in       = step_ff;
      total_in      = total_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      cell_ctrl     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               rsp_valid_in = 1'b1;
               rsp_entry_in = '0;
               if (req_tuser[0] == OP_INSERT) begin
                  priority if (ins_entry.pri == 8'd0) begin
                     rsp_status_in = ST_ZERO_PRI;
                  end else if (occ_ff == DEPTH_LEN) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     cell_ctrl.ins    = 1'b1;
                     occ_in           = occ_ff + ONE_LEN;
                     rsp_status_in    = ST_OK;
                     rsp_entry_in.num = ins_entry.num;
                  end
               end else if (occ_ff == '0) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_valid_in = rsp_valid_ff && !rsp_tready;
                  total_in     = occ_ff;
                  step_in      = '0;
                  state_in     = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // The head passes by once per cycle; a strictly higher priority wins.
            cell_ctrl.rot  = 1'b1;
            cell_ctrl.keep = 1'b1;
            if ((step_ff == '0) || (head.pri > best_ff.pri)) begin
               best_in     = head;
               best_idx_in = step_ff;
            end
            if (last_step) begin
               step_in  = '0;
               state_in = S_PURGE;
            end else begin
               step_in = step_ff + ONE_LEN;
            end
         end
         S_PURGE: begin
            // Rotate again, dropping the chosen job instead of wrapping it.
            cell_ctrl.rot  = 1'b1;
            cell_ctrl.keep = (step_ff != best_idx_ff);
            if (step_ff == best_idx_ff) begin
               occ_in = occ_ff - ONE_LEN;
            end
            if (last_step) begin
               state_in = S_DONE;
            end else begin
               step_in = step_ff + ONE_LEN;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_entry_in  = best_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs; payload fields are not reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff       <= step_in;
      total_ff      <= total_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
   end

   // Chain of job slots; the last slot's neighbor input is tied to slot 0 but never selected.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type next_entry;
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_entry = cell_q[0];
      end else begin : g_mid
         assign next_entry = cell_q[i+1];
      end
      spjq_cell #(
         .QUEUE_DEPTH (QUEUE_DEPTH),
         .CELL_INDEX  (i)
      ) u_cell (
         .clock        (clock),
         .ctrl_i       (cell_ctrl),
         .len_i        (occ_ff),
         .ins_entry_i  (ins_entry),
         .next_entry_i (next_entry),
         .head_entry_i (head),
         .entry_o      (cell_q[i])
      );
   end

   // Response word.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = RSP_USER_W'(rsp_status_ff);
   assign rsp_tdata  = {3'b000, rsp_entry_ff.act, rsp_entry_ff.arg,
                        rsp_entry_ff.pri, rsp_entry_ff.num};

   `SPJQ_ASSERT_IMPLY(a_occ_bound, clock, reset, 1'b1, occ_ff <= DEPTH_LEN, "occupancy overflow")
   `SPJQ_ASSERT_NEXT(a_one_drop, clock, reset, (state_ff == S_PURGE) && last_step, occ_ff == $past(total_ff) - ONE_LEN, "purge did not remove exactly one job")
   `SPJQ_ASSERT_IMPLY(a_best_range, clock, reset, state_ff == S_PURGE, best_idx_ff < total_ff, "chosen job outside the queue")
   `SPJQ_ASSERT_NEXT(a_accept_moves, clock, reset, req_accept, rsp_valid_ff || (state_ff == S_SCAN), "accepted request left no trace")

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the stable priority job queue: directed corners,
// fill and drain rounds, random traffic, back-pressure and full-rate stretches.
// Depends on spjq_pkg and stable_priority_job_queue_top; needs no other file.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import spjq_pkg::*;

   localparam int unsigned DEPTH       = QUEUE_DEPTH_DEF;
   localparam int unsigned STALL_LIMIT = 4000;
   localparam int unsigned LONG_HOLD   = 300;
   localparam int unsigned TAIL_CYCLES = 2 * DEPTH + 8;

   // One job as the queue stores it.
   typedef struct {
      logic [7:0]         pri;
      logic signed [31:0] arg;
      logic [7:0]         act;
      logic [NUM_W-1:0]   num;
   } job_rec_type;

   // One response word as the queue should return it.
   typedef struct {
      status_type         status;
      logic [NUM_W-1:0]   num;
      logic [7:0]         pri;
      logic signed [31:0] arg;
      logic [7:0]         act;
   } reply_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   // Shadow copy of the queue contents, oldest job first.
   job_rec_type job_store[$];
   // Responses still owed by the block, oldest first.
   reply_type   owed_replies[$];

   int unsigned error_count = 0;
   int unsigned word_count = 0;
   int unsigned status_count[4] = '{0, 0, 0, 0};
   int unsigned tie_extracts = 0;
   int unsigned peak_jobs = 0;
   bit          idle_enable = 1'b1;
   bit          hold_request = 1'b0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;

   stable_priority_job_queue_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Work out the response to one accepted request and update the shadow queue.
   function automatic reply_type apply_job_request(logic op, logic [7:0] pri,
                                                   logic signed [31:0] arg,
                                                   logic [7:0] act);
      reply_type   rep;
      job_rec_type job;
      int          best;
      int          ties;
      rep = '{ST_OK, '0, '0, '0, '0};
      if (op == OP_INSERT) begin
         if (pri == 8'd0) begin
            rep.status = ST_ZERO_PRI;
         end else if (job_store.size() >= DEPTH) begin
            rep.status = ST_FULL;
         end else begin
            job.pri = pri;
            job.arg = arg;
            job.act = act;
            job.num = NUM_W'(job_store.size() + 1);
            job_store.push_back(job);
            rep.num = job.num;
            if (job_store.size() > peak_jobs) begin
               peak_jobs = job_store.size();
            end
         end
      end else if (job_store.size() == 0) begin
         rep.status = ST_EMPTY;
      end else begin
         // The first job holding the highest priority wins.
         best = 0;
         for (int i = 1; i < job_store.size(); i++) begin
            if (job_store[i].pri > job_store[best].pri) begin
               best = i;
            end
         end
         ties = 0;
         foreach (job_store[i]) begin
            if (job_store[i].pri == job_store[best].pri) begin
               ties++;
            end
         end
         if (ties > 1) begin
            tie_extracts++;
         end
         rep.num = job_store[best].num;
         rep.pri = job_store[best].pri;
         rep.arg = job_store[best].arg;
         rep.act = job_store[best].act;
         job_store.delete(best);
      end
      status_count[rep.status]++;
      return rep;
   endfunction

   function automatic void check_field(string label, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         error_count++;
      end
   endfunction

   // Offer one request word and wait until the block takes it.
   // The valid is left high so a following word can go out back to back.
   task automatic send_word(logic op, logic [7:0] pri, logic signed [31:0] arg,
                            logic [7:0] act);
      while (idle_enable && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {act, arg, pri};
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      owed_replies.push_back(apply_job_request(op, pri, arg, act));
      word_count++;
   endtask

   // Random content; priorities mostly from a narrow band so that ties are common.
   task automatic send_random_job(logic op);
      logic [7:0] pri;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 4) begin
         pri = 8'd0;
      end else if (pick < 34) begin
         pri = 8'($urandom_range(255));
      end else begin
         pri = 8'($urandom_range(6, 1));
      end
      send_word(op, pri, $urandom(), 8'($urandom_range(255)));
   endtask

   // Stop offering words until every owed response has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (owed_replies.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Corners of the fields, the zero-priority refusal, empty extract and a priority tie.
   task automatic test_directed();
      send_word(OP_EXTRACT, 8'd0, 32'sd0, 8'd0);
      send_word(OP_INSERT, 8'd0, 32'sh7fffffff, 8'hff);
      send_word(OP_INSERT, 8'd255, 32'sh7fffffff, 8'hff);
      send_word(OP_INSERT, 8'd1, 32'sh80000000, 8'h00);
      send_word(OP_INSERT, 8'd255, -32'sd1, 8'h5a);
      send_word(OP_INSERT, 8'd128, 32'sd0, 8'ha5);
      send_word(OP_EXTRACT, 8'hff, -32'sd1, 8'hff);
      send_word(OP_EXTRACT, 8'h00, 32'sd0, 8'h00);
      send_word(OP_EXTRACT, 8'h55, 32'sh55555555, 8'h55);
      send_word(OP_EXTRACT, 8'haa, 32'shaaaaaaaa, 8'haa);
      send_word(OP_EXTRACT, 8'd7, 32'sd7, 8'd7);
      wait_drained();
   endtask

   // Fill the queue to the top, try refused inserts, then empty it again.
   task automatic test_fill_and_drain(int rounds);
      for (int r = 0; r < rounds; r++) begin
         while (job_store.size() < DEPTH) begin
            send_word(OP_INSERT, 8'($urandom_range(4, 1)), $urandom(),
                      8'($urandom_range(255)));
         end
         send_word(OP_INSERT, 8'($urandom_range(255, 1)), $urandom(), 8'($urandom_range(255)));
         send_word(OP_INSERT, 8'd0, $urandom(), 8'($urandom_range(255)));
         send_random_job(OP_INSERT);
         while (job_store.size() > 0) begin
            send_random_job(OP_EXTRACT);
         end
         send_random_job(OP_EXTRACT);
      end
   endtask

   // Random mix of operations, steered by the fill level so the queue wanders
   // between empty and full.
   task automatic test_random_mix(int count);
      int unsigned ins_pct;
      for (int n = 0; n < count; n++) begin
         if (job_store.size() < 3) begin
            ins_pct = 75;
         end else if (job_store.size() > DEPTH - 3) begin
            ins_pct = 30;
         end else begin
            ins_pct = 55;
         end
         send_random_job(($urandom_range(99) < ins_pct) ? OP_INSERT : OP_EXTRACT);
      end
   endtask

   // Receiver holds off for a long stretch while requests keep coming.
   task automatic test_backpressure();
      hold_request = 1'b1;
      for (int n = 0; n < 24; n++) begin
         send_random_job(($urandom_range(99) < 60) ? OP_INSERT : OP_EXTRACT);
      end
      wait_drained();
   endtask

   // A stretch at full rate on both sides.
   task automatic test_full_rate(int count);
      idle_enable = 1'b0;
      test_random_mix(count);
      wait_drained();
      idle_enable = 1'b1;
   endtask

   // Response side: random stalls, plus a long hold-off when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(idle_enable && $urandom_range(99) < 24);
         end
      end
   end

   // Compare every response word with the oldest owed response.
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (owed_replies.size() == 0) begin
            $display("%0t: unexpected response word, status %0d data %0h",
                     $time, rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            want = owed_replies.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_tuser));
            check_field("job_number", 32'(want.num), 32'(rsp_tdata[4:0]));
            check_field("out_priority", 32'(want.pri), 32'(rsp_tdata[12:5]));
            check_field("out_argument", want.arg, rsp_tdata[44:13]);
            check_field("out_action_id", 32'(want.act), 32'(rsp_tdata[52:45]));
            check_field("pad", 32'd0, 32'(rsp_tdata[55:53]));
         end
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, %0d responses still owed", $time, owed_replies.size());
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_fill_and_drain(2);
      test_random_mix(420);
      test_backpressure();
      test_full_rate(80);
      test_fill_and_drain(1);

      // Let any stray words show up before the verdict.
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (owed_replies.size() != 0) begin
         error_count++;
      end

      $display("Covered %0d words: %0d ok, %0d empty, %0d full, %0d zero-priority.",
               word_count, status_count[ST_OK], status_count[ST_EMPTY],
               status_count[ST_FULL], status_count[ST_ZERO_PRI]);
      $display("Peak occupancy %0d of %0d, %0d extracts settled a priority tie.",
               peak_jobs, DEPTH, tie_extracts);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
